// ----- rtl/ccr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccr_pkg
// shared constants, types and codes for the closed catmull-rom evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

	localparam int NUM_POINTS     = 16;
	localparam int IDX_BITS       = $clog2(NUM_POINTS);
	localparam int COORD_BITS     = 16;
	localparam int POS_BITS       = 16;
	localparam int WFRAC          = 16;
	localparam int BANKS          = 4;
	localparam int BANK_BITS      = 2;
	localparam int BANK_ADDR_BITS = IDX_BITS - BANK_BITS;
	localparam int BANK_DEPTH     = NUM_POINTS / BANKS;
	localparam int W_BITS         = WFRAC + 4;
	localparam int PROD_BITS      = W_BITS + COORD_BITS;
	localparam int ACC_BITS       = PROD_BITS + 2;
	localparam int RES_BITS       = ACC_BITS - (WFRAC + 1);

	localparam logic signed [W_BITS-1:0] W_TWO = W_BITS'(2 ** (WFRAC + 1));
	localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(2 ** WFRAC);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [WFRAC-1:0] frac_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

endpackage

`default_nettype wire

// ----- rtl/closed_catmull_rom_point_eval.sv -----
// ----------------------------------------------------------------------------
// closed_catmull_rom_point_eval
// uniform catmull-rom spline evaluator over a closed loop of 16 points
//
// input channel: in_valid/in_ready with operation, point_index, point_x/y/z
// and position. a load item writes one point into the four-bank point store
// and gives no result. an evaluate item reads its four neighboring points,
// one from each bank, in the cycle it is accepted.
// output channel: out_valid/out_ready with curve_x/y/z, one item per
// evaluate, in order.
// registers from accepted item to result, in order: memory read, square,
// cube, weights, products, sum, output register.
// throughput: one item per cycle unless the output stalls; each stage moves
// whenever the stage after it is empty or moving, so bubbles are squeezed out
// and the input keeps accepting while a result waits and a stage is empty.
// reset: clears all stage valids and out_valid; the point store is not
// cleared, and an evaluate must only touch points that were loaded.
// a stalled receiver holds the output item; the pipeline fills up behind it
// and in_ready falls once every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module closed_catmull_rom_point_eval (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      operation,
	input  wire [3:0]                point_index,
	input  wire signed [15:0]        point_x,
	input  wire signed [15:0]        point_y,
	input  wire signed [15:0]        point_z,
	input  wire [15:0]               position,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic signed [15:0]       curve_x,
	output logic signed [15:0]       curve_y,
	output logic signed [15:0]       curve_z
);
	import ccr_pkg::*;

	pipe_en_t en;
	logic     en_out;
	logic     en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic     in_fire, eval_fire, load_fire;
	idx_t     seg;
	frac_t    u;
	point_t   wr_point;
	point_t   res;
	point_t [BANKS-1:0] pts;

	assign en_out = !out_valid || out_ready;
	assign en_s6  = !v_s6 || en_out;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign en = '{s1: en_s1, s2: en_s2, s3: en_s3, s4: en_s4, s5: en_s5, s6: en_s6};

	assign in_ready  = en_s1;
	assign in_fire   = in_valid && in_ready;
	assign eval_fire = in_fire && (op_t'(operation) == OP_EVAL);
	assign load_fire = in_fire && (op_t'(operation) == OP_LOAD);

	assign seg = position[POS_BITS-1 -: IDX_BITS];
	assign u   = {position[POS_BITS-IDX_BITS-1:0], {IDX_BITS{1'b0}}};

	assign wr_point.x = point_x;
	assign wr_point.y = point_y;
	assign wr_point.z = point_z;

	ccr_point_store u_store (
		.clk      (clk),
		.we       (load_fire),
		.wr_idx   (point_index),
		.wr_point (wr_point),
		.rd_en    (en_s1),
		.seg      (seg),
		.pts      (pts)
	);

	ccr_blend u_blend (
		.clk    (clk),
		.en     (en),
		.u_in   (u),
		.pts_in (pts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= eval_fire;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_out) out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s6) begin
			curve_x <= res.x;
			curve_y <= res.y;
			curve_z <= res.z;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ccr_point_store.sv -----
// ----------------------------------------------------------------------------
// ccr_point_store
// control point memory in four banks, one read port each, so the four
// neighboring points of a segment are read in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_point_store (
	input  wire                                 clk,
	input  wire                                 we,
	input  wire ccr_pkg::idx_t                  wr_idx,
	input  wire ccr_pkg::point_t                wr_point,
	input  wire                                 rd_en,
	input  wire ccr_pkg::idx_t                  seg,
	output ccr_pkg::point_t [ccr_pkg::BANKS-1:0] pts
);
	import ccr_pkg::*;

	idx_t                 base;
	logic [BANK_BITS-1:0] base_lo_s1;
	point_t               rd_s1 [BANKS];

	assign base = seg - idx_t'(1);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			base_lo_s1 <= base[BANK_BITS-1:0];
		end
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		point_t                    mem [BANK_DEPTH];
		logic [BANK_BITS-1:0]      k;
		idx_t                      ridx;
		logic [BANK_ADDR_BITS-1:0] raddr;

		assign k     = BANK_BITS'(b) - base[BANK_BITS-1:0];
		assign ridx  = base + idx_t'(k);
		assign raddr = ridx[IDX_BITS-1:BANK_BITS];

		always_ff @(posedge clk) begin
			if (we && (wr_idx[BANK_BITS-1:0] == BANK_BITS'(b))) begin
				mem[wr_idx[IDX_BITS-1:BANK_BITS]] <= wr_point;
			end
			if (rd_en) begin
				rd_s1[b] <= mem[raddr];
			end
		end
	end

	// put the bank outputs back in segment order
	always_comb begin
		for (int j = 0; j < BANKS; j++) begin
			pts[j] = rd_s1[BANK_BITS'(base_lo_s1 + BANK_BITS'(j))];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ccr_blend.sv -----
// ----------------------------------------------------------------------------
// ccr_blend
// basis weight pipeline and weighted sum of the four points, with rounding
// and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_blend (
	input  wire                                 clk,
	input  wire ccr_pkg::pipe_en_t              en,
	input  wire ccr_pkg::frac_t                 u_in,
	input  wire ccr_pkg::point_t [ccr_pkg::BANKS-1:0] pts_in,
	output ccr_pkg::point_t                     res
);
	import ccr_pkg::*;

	function automatic coord_t round_sat(input logic signed [ACC_BITS-1:0] acc);
		logic signed [RES_BITS-1:0] r;
		logic signed [RES_BITS-1:0] hi;
		logic signed [RES_BITS-1:0] lo;
		r  = RES_BITS'(acc >>> (WFRAC + 1));
		hi = RES_BITS'(2 ** (COORD_BITS - 1) - 1);
		lo = -hi - RES_BITS'(1);
		if (r > hi) begin
			return coord_t'(hi);
		end else if (r < lo) begin
			return coord_t'(lo);
		end
		return coord_t'(r);
	endfunction

	frac_t u_s1;
	frac_t u_s2, u2_s2;
	frac_t u_s3, u2_s3, u3_s3;
	point_t [BANKS-1:0] pts_s2, pts_s3, pts_s4;
	logic signed [W_BITS-1:0] w_s4 [BANKS];
	logic signed [PROD_BITS-1:0] px_s5 [BANKS];
	logic signed [PROD_BITS-1:0] py_s5 [BANKS];
	logic signed [PROD_BITS-1:0] pz_s5 [BANKS];
	logic signed [ACC_BITS-1:0] ax_s6, ay_s6, az_s6;

	logic [2*WFRAC-1:0] sq, cube;
	logic signed [W_BITS-1:0] a1, a2, a3;
	logic signed [W_BITS-1:0] w_d [BANKS];
	logic signed [PROD_BITS-1:0] px_d [BANKS];
	logic signed [PROD_BITS-1:0] py_d [BANKS];
	logic signed [PROD_BITS-1:0] pz_d [BANKS];

	assign sq   = {{WFRAC{1'b0}}, u_s1} * {{WFRAC{1'b0}}, u_s1};
	assign cube = {{WFRAC{1'b0}}, u2_s2} * {{WFRAC{1'b0}}, u_s2};

	assign a1 = W_BITS'(u_s3);
	assign a2 = W_BITS'(u2_s3);
	assign a3 = W_BITS'(u3_s3);

	always_comb begin
		w_d[0] = -a3 + (a2 <<< 1) - a1;
		w_d[1] = (a3 <<< 1) + a3 - (a2 <<< 2) - a2 + W_TWO;
		w_d[2] = -((a3 <<< 1) + a3) + (a2 <<< 2) + a1;
		w_d[3] = a3 - a2;
	end

	always_comb begin
		for (int k = 0; k < BANKS; k++) begin
			px_d[k] = PROD_BITS'(w_s4[k]) * PROD_BITS'(pts_s4[k].x);
			py_d[k] = PROD_BITS'(w_s4[k]) * PROD_BITS'(pts_s4[k].y);
			pz_d[k] = PROD_BITS'(w_s4[k]) * PROD_BITS'(pts_s4[k].z);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			u_s1 <= u_in;
		end
		if (en.s2) begin
			u_s2   <= u_s1;
			u2_s2  <= sq[2*WFRAC-1:WFRAC];
			pts_s2 <= pts_in;
		end
		if (en.s3) begin
			u_s3   <= u_s2;
			u2_s3  <= u2_s2;
			u3_s3  <= cube[2*WFRAC-1:WFRAC];
			pts_s3 <= pts_s2;
		end
		if (en.s4) begin
			w_s4   <= w_d;
			pts_s4 <= pts_s3;
		end
		if (en.s5) begin
			px_s5 <= px_d;
			py_s5 <= py_d;
			pz_s5 <= pz_d;
		end
		if (en.s6) begin
			ax_s6 <= ACC_BITS'(px_s5[0]) + ACC_BITS'(px_s5[1]) + ACC_BITS'(px_s5[2])
				+ ACC_BITS'(px_s5[3]) + ACC_HALF;
			ay_s6 <= ACC_BITS'(py_s5[0]) + ACC_BITS'(py_s5[1]) + ACC_BITS'(py_s5[2])
				+ ACC_BITS'(py_s5[3]) + ACC_HALF;
			az_s6 <= ACC_BITS'(pz_s5[0]) + ACC_BITS'(pz_s5[1]) + ACC_BITS'(pz_s5[2])
				+ ACC_BITS'(pz_s5[3]) + ACC_HALF;
		end
	end

	assign res.x = round_sat(ax_s6);
	assign res.y = round_sat(ay_s6);
	assign res.z = round_sat(az_s6);

endmodule

`default_nettype wire
